// ----- rtl/core/dmx_rdm_receive_framer_macros.svh -----
// Assertion helpers for the framer core source.
`ifndef DMX_RDM_RECEIVE_FRAMER_MACROS_SVH
`define DMX_RDM_RECEIVE_FRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DRRF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/drrf_pkg.sv -----
`default_nettype none
package drrf_pkg;

   localparam int unsigned UNIVERSE_SLOTS = 512;
   localparam int unsigned RDM_MAX_BYTES  = 256;
   localparam int unsigned UID_BYTES      = 6;
   localparam int unsigned POS_W          = 10;
   localparam int unsigned DISC_W         = 5;
   localparam int unsigned EUID_BYTES     = 2 * UID_BYTES;
   localparam int unsigned DISC_CS_BYTES  = 4;
   localparam int unsigned PREAMBLE_LAST  = 9;

   localparam logic [7:0] SC_DMX   = 8'h00;
   localparam logic [7:0] SC_RDM   = 8'hCC;
   localparam logic [7:0] SUB_SC   = 8'h01;
   localparam logic [7:0] DISC_PRE = 8'hFE;
   localparam logic [7:0] DISC_SEP = 8'hAA;

   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_BREAK = 2'd1,
      OP_TICK  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CM_NONE = 2'd0,
      CM_DMX  = 2'd1,
      CM_RDM  = 2'd2
   } commit_type;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_PREBREAK = 4'd1,
      PH_BREAK    = 4'd2,
      PH_MAB      = 4'd3,
      PH_DMX      = 4'd4,
      PH_RDM      = 4'd5,
      PH_CSH      = 4'd6,
      PH_CSL      = 4'd7,
      PH_DFE      = 4'd8,
      PH_DEUID    = 4'd9,
      PH_DECS     = 4'd10,
      PH_INTER    = 4'd11
   } phase_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  rx_byte;
      logic [31:0] time_us;
   } item_type;

   typedef struct packed {
      logic             store_valid;
      logic             store_to_rdm;
      logic [POS_W-1:0] store_index;
      logic [7:0]       store_byte;
      commit_type       commit;
      logic [POS_W-1:0] slot_count;
      logic [31:0]      break_gap_us;
      logic [31:0]      slot_gap_us;
      logic [31:0]      dmx_frames;
      logic [31:0]      rdm_frames;
      phase_type        rx_state;
   } result_type;

   typedef struct packed {
      phase_type         phase;
      logic [POS_W-1:0]  byte_pos;
      logic [15:0]       rdm_sum;
      logic [7:0]        rdm_length;
      logic [7:0]        rdm_sub_code;
      logic [DISC_W-1:0] disc_count;
      logic [31:0]       last_event_time;
      logic [31:0]       break_stamp;
      logic [31:0]       prev_dmx_break_time;
      logic              prev_break_was_dmx;
      logic [31:0]       break_gap;
      logic [31:0]       slot_gap;
      logic [31:0]       dmx_count;
      logic [31:0]       rdm_count;
   } state_type;

endpackage
`default_nettype wire

// ----- rtl/core/drrf_in_stage.sv -----
`default_nettype none
module drrf_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_operation,
   input  wire logic [7:0]         req_rx_byte,
   input  wire logic [31:0]        req_time_us,
   output logic                    req_stall,
   input  wire logic               advance,
   output logic                    item_valid,
   output drrf_pkg::item_type      item
);

   logic               valid_ff;
   logic               valid_in;
   drrf_pkg::item_type item_ff;
   logic               take;

   // hold the request while the result side cannot take it
   assign req_stall  = valid_ff && !advance;
   assign take       = req_valid && !req_stall;
   assign valid_in   = take || (valid_ff && !advance);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.operation <= drrf_pkg::op_type'(req_operation);
         item_ff.rx_byte   <= req_rx_byte;
         item_ff.time_us   <= req_time_us;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/drrf_frame_core.sv -----
`default_nettype none
`include "dmx_rdm_receive_framer_macros.svh"
module drrf_frame_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire drrf_pkg::item_type  item,
   output drrf_pkg::result_type     result
);

   drrf_pkg::state_type  state_ff;
   drrf_pkg::state_type  state_in;
   drrf_pkg::result_type res;

   always_comb begin
      logic [drrf_pkg::POS_W-1:0]  pos_inc;
      logic [drrf_pkg::POS_W:0]    pos_wide;
      logic [7:0]                  len_next;
      logic [15:0]                 sum_next;
      logic [drrf_pkg::DISC_W-1:0] disc_inc;
      logic [31:0]                 gap_now;

      pos_inc  = state_ff.byte_pos + drrf_pkg::POS_W'(1);
      pos_wide = {1'b0, state_ff.byte_pos} + (drrf_pkg::POS_W+1)'(1);
      len_next = (state_ff.byte_pos == drrf_pkg::POS_W'(2)) ? item.rx_byte
                                                             : state_ff.rdm_length;
      sum_next = state_ff.rdm_sum;
      disc_inc = state_ff.disc_count + drrf_pkg::DISC_W'(1);
      gap_now  = item.time_us - state_ff.last_event_time;

      state_in = state_ff;
      res      = '0;

      case (item.operation)
         drrf_pkg::OP_BYTE: begin
            state_in.last_event_time = item.time_us;
            case (state_ff.phase)
               drrf_pkg::PH_IDLE: begin
                  if (item.rx_byte == drrf_pkg::DISC_PRE) begin
                     res.store_valid   = 1'b1;
                     res.store_to_rdm  = 1'b1;
                     res.store_byte    = item.rx_byte;
                     state_in.byte_pos = drrf_pkg::POS_W'(1);
                     state_in.phase    = drrf_pkg::PH_DFE;
                  end
               end
               drrf_pkg::PH_PREBREAK: begin
                  state_in.phase = drrf_pkg::PH_BREAK;
               end
               drrf_pkg::PH_BREAK: begin
                  if (item.rx_byte == drrf_pkg::SC_DMX) begin
                     res.store_valid   = 1'b1;
                     res.store_byte    = item.rx_byte;
                     state_in.byte_pos = drrf_pkg::POS_W'(1);
                     state_in.phase    = drrf_pkg::PH_DMX;
                     state_in.dmx_count = state_ff.dmx_count + 32'd1;
                     if (state_ff.prev_break_was_dmx) begin
                        state_in.break_gap = state_ff.break_stamp
                                             - state_ff.prev_dmx_break_time;
                     end
                     state_in.prev_break_was_dmx  = 1'b1;
                     state_in.prev_dmx_break_time = state_ff.break_stamp;
                  end else if (item.rx_byte == drrf_pkg::SC_RDM) begin
                     res.store_valid    = 1'b1;
                     res.store_to_rdm   = 1'b1;
                     res.store_byte     = item.rx_byte;
                     state_in.byte_pos  = drrf_pkg::POS_W'(1);
                     state_in.phase     = drrf_pkg::PH_RDM;
                     state_in.rdm_sum   = {8'h00, drrf_pkg::SC_RDM};
                     state_in.rdm_length   = 8'h00;
                     state_in.rdm_sub_code = 8'h00;
                     state_in.rdm_count = state_ff.rdm_count + 32'd1;
                     state_in.prev_break_was_dmx = 1'b0;
                  end else begin
                     state_in.phase = drrf_pkg::PH_IDLE;
                     state_in.prev_break_was_dmx = 1'b0;
                  end
               end
               drrf_pkg::PH_DMX: begin
                  state_in.slot_gap = gap_now;
                  res.store_valid   = 1'b1;
                  res.store_index   = state_ff.byte_pos;
                  res.store_byte    = item.rx_byte;
                  state_in.byte_pos = pos_inc;
                  if (pos_wide > (drrf_pkg::POS_W+1)'(drrf_pkg::UNIVERSE_SLOTS)) begin
                     state_in.phase = drrf_pkg::PH_IDLE;
                     res.commit     = drrf_pkg::CM_DMX;
                     res.slot_count = drrf_pkg::POS_W'(drrf_pkg::UNIVERSE_SLOTS);
                  end
               end
               drrf_pkg::PH_RDM: begin
                  if (state_ff.byte_pos > drrf_pkg::POS_W'(drrf_pkg::RDM_MAX_BYTES)) begin
                     state_in.phase = drrf_pkg::PH_IDLE;
                  end else begin
                     if (state_ff.byte_pos == drrf_pkg::POS_W'(1)) begin
                        state_in.rdm_sub_code = item.rx_byte;
                     end
                     state_in.rdm_length = len_next;
                     state_in.rdm_sum    = state_ff.rdm_sum + {8'h00, item.rx_byte};
                     res.store_valid     = 1'b1;
                     res.store_to_rdm    = 1'b1;
                     res.store_index     = state_ff.byte_pos;
                     res.store_byte      = item.rx_byte;
                     state_in.byte_pos   = pos_inc;
                     if (pos_inc >= drrf_pkg::POS_W'(3)
                         && pos_inc == drrf_pkg::POS_W'(len_next)) begin
                        state_in.phase = drrf_pkg::PH_CSH;
                     end
                  end
               end
               drrf_pkg::PH_CSH: begin
                  res.store_valid   = 1'b1;
                  res.store_to_rdm  = 1'b1;
                  res.store_index   = state_ff.byte_pos;
                  res.store_byte    = item.rx_byte;
                  state_in.byte_pos = pos_inc;
                  state_in.rdm_sum  = state_ff.rdm_sum - {item.rx_byte, 8'h00};
                  state_in.phase    = drrf_pkg::PH_CSL;
               end
               drrf_pkg::PH_CSL: begin
                  sum_next          = state_ff.rdm_sum - {8'h00, item.rx_byte};
                  res.store_valid   = 1'b1;
                  res.store_to_rdm  = 1'b1;
                  res.store_index   = state_ff.byte_pos;
                  res.store_byte    = item.rx_byte;
                  state_in.byte_pos = pos_inc;
                  state_in.rdm_sum  = sum_next;
                  if (sum_next == 16'h0000 && state_ff.rdm_sub_code == drrf_pkg::SUB_SC) begin
                     res.commit = drrf_pkg::CM_RDM;
                  end
                  state_in.phase = drrf_pkg::PH_IDLE;
               end
               drrf_pkg::PH_DFE: begin
                  res.store_valid   = 1'b1;
                  res.store_to_rdm  = 1'b1;
                  res.store_index   = state_ff.byte_pos;
                  res.store_byte    = item.rx_byte;
                  state_in.byte_pos = pos_inc;
                  if (item.rx_byte == drrf_pkg::DISC_SEP
                      || pos_inc == drrf_pkg::POS_W'(drrf_pkg::PREAMBLE_LAST)) begin
                     state_in.phase      = drrf_pkg::PH_DEUID;
                     state_in.disc_count = '0;
                  end
               end
               drrf_pkg::PH_DEUID: begin
                  res.store_valid     = 1'b1;
                  res.store_to_rdm    = 1'b1;
                  res.store_index     = state_ff.byte_pos;
                  res.store_byte      = item.rx_byte;
                  state_in.byte_pos   = pos_inc;
                  state_in.disc_count = disc_inc;
                  if (disc_inc == drrf_pkg::DISC_W'(drrf_pkg::EUID_BYTES)) begin
                     state_in.phase      = drrf_pkg::PH_DECS;
                     state_in.disc_count = '0;
                  end
               end
               drrf_pkg::PH_DECS: begin
                  res.store_valid     = 1'b1;
                  res.store_to_rdm    = 1'b1;
                  res.store_index     = state_ff.byte_pos;
                  res.store_byte      = item.rx_byte;
                  state_in.byte_pos   = pos_inc;
                  state_in.disc_count = disc_inc;
                  if (disc_inc == drrf_pkg::DISC_W'(drrf_pkg::DISC_CS_BYTES)) begin
                     state_in.phase = drrf_pkg::PH_IDLE;
                     res.commit     = drrf_pkg::CM_RDM;
                  end
               end
               default: begin
                  state_in.phase = drrf_pkg::PH_IDLE;
                  state_in.prev_break_was_dmx = 1'b0;
               end
            endcase
         end
         drrf_pkg::OP_BREAK: begin
            state_in.phase           = drrf_pkg::PH_PREBREAK;
            state_in.break_stamp     = item.time_us;
            state_in.last_event_time = item.time_us;
         end
         drrf_pkg::OP_TICK: begin
            if (state_ff.phase == drrf_pkg::PH_DMX && gap_now > state_ff.slot_gap) begin
               state_in.phase = drrf_pkg::PH_IDLE;
               res.commit     = drrf_pkg::CM_DMX;
               res.slot_count = state_ff.byte_pos - drrf_pkg::POS_W'(1);
            end
         end
         default: begin
            state_in = state_ff;
         end
      endcase

      res.break_gap_us = state_in.break_gap;
      res.slot_gap_us  = state_in.slot_gap;
      res.dmx_frames   = state_in.dmx_count;
      res.rdm_frames   = state_in.rdm_count;
      res.rx_state     = state_in.phase;
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   `DRRF_ASSERT_NOW(a_dmx_commit_idle, clock, reset,
      advance && res.commit == drrf_pkg::CM_DMX,
      state_in.phase == drrf_pkg::PH_IDLE,
      "DMX commit without return to idle")

   `DRRF_ASSERT_NOW(a_dmx_pos_range, clock, reset,
      state_ff.phase == drrf_pkg::PH_DMX,
      state_ff.byte_pos != '0
      && state_ff.byte_pos <= drrf_pkg::POS_W'(drrf_pkg::UNIVERSE_SLOTS),
      "DMX slot position out of range")

   `DRRF_ASSERT_NOW(a_dmx_count_start, clock, reset,
      advance && state_in.dmx_count != state_ff.dmx_count,
      res.store_valid && !res.store_to_rdm && res.store_index == '0,
      "DMX frame counted without start code store")

   `DRRF_ASSERT_NEXT(a_hold_when_idle, clock, reset,
      !advance,
      $stable(state_ff),
      "frame state changed without an advancing request")

endmodule
`default_nettype wire

// ----- rtl/core/dmx_rdm_receive_framer.sv -----
`default_nettype none
// DMX512/RDM receive framer: takes one UART receive event per request (data byte,
// line break or slot-timeout tick, each with a microsecond timestamp) and returns
// exactly one response per request with the byte store, any frame commit and the
// status counters. A request can be taken every clock cycle while req_stall is low;
// its response reaches the rsp_ ports through the request register, which feeds the
// single-pass framing logic, and the response register, which captures that logic's
// output. Stalls on the response side back up into req_stall only when both
// registers are full.
module dmx_rdm_receive_framer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [31:0] req_time_us,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_store_valid,
   output logic             rsp_store_to_rdm,
   output logic [9:0]       rsp_store_index,
   output logic [7:0]       rsp_store_byte,
   output logic [1:0]       rsp_commit,
   output logic [9:0]       rsp_slot_count,
   output logic [31:0]      rsp_break_gap_us,
   output logic [31:0]      rsp_slot_gap_us,
   output logic [31:0]      rsp_dmx_frames,
   output logic [31:0]      rsp_rdm_frames,
   output logic [3:0]       rsp_rx_state
);

   logic                 item_valid;
   drrf_pkg::item_type   item;
   drrf_pkg::result_type result;
   drrf_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 advance;

   assign advance      = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   drrf_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_rx_byte   (req_rx_byte),
      .req_time_us   (req_time_us),
      .req_stall     (req_stall),
      .advance       (advance),
      .item_valid    (item_valid),
      .item          (item)
   );

   drrf_frame_core u_frame_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_store_valid  = rsp_ff.store_valid;
   assign rsp_store_to_rdm = rsp_ff.store_to_rdm;
   assign rsp_store_index  = rsp_ff.store_index;
   assign rsp_store_byte   = rsp_ff.store_byte;
   assign rsp_commit       = rsp_ff.commit;
   assign rsp_slot_count   = rsp_ff.slot_count;
   assign rsp_break_gap_us = rsp_ff.break_gap_us;
   assign rsp_slot_gap_us  = rsp_ff.slot_gap_us;
   assign rsp_dmx_frames   = rsp_ff.dmx_frames;
   assign rsp_rdm_frames   = rsp_ff.rdm_frames;
   assign rsp_rx_state     = rsp_ff.rx_state;

endmodule
`default_nettype wire
